// ----- src/rat_pkg.sv -----
// Shared constants, command codes and payload types of the register alias table.
`default_nettype none
package rat_pkg;

    localparam int NUM_REGS = 32;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 5;
    localparam int TAG_W    = 4;
    localparam int ORDER_W  = 16;
    // Wide enough to hold any register index and the register count itself.
    localparam int IDX_CMP_W = 7;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DONE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   reg_index;
        logic [TAG_W-1:0]   rs_tag;
        logic [ORDER_W-1:0] seq_order;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic               hit;
        logic [TAG_W-1:0]   tag_out;
        logic [ORDER_W-1:0] order_out;
        logic               all_empty;
    } t_rsp;

endpackage
`default_nettype wire

// ----- src/rat_cmd_if.sv -----
// Command channel of the register alias table: valid, ready and one command.
`default_nettype none
interface rat_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [rat_pkg::CMD_W-1:0]   cmd;
    logic [rat_pkg::IDX_W-1:0]   reg_index;
    logic [rat_pkg::TAG_W-1:0]   rs_tag;
    logic [rat_pkg::ORDER_W-1:0] seq_order;

    modport source (output valid, output cmd, output reg_index, output rs_tag,
                    output seq_order, input ready);
    modport sink   (input valid, input cmd, input reg_index, input rs_tag,
                    input seq_order, output ready);
endinterface
`default_nettype wire

// ----- src/rat_rsp_if.sv -----
// Result channel of the register alias table: valid, ready and one result.
`default_nettype none
interface rat_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        hit;
    logic [rat_pkg::TAG_W-1:0]   tag_out;
    logic [rat_pkg::ORDER_W-1:0] order_out;
    logic                        all_empty;

    modport source (output valid, output accepted, output hit, output tag_out,
                    output order_out, output all_empty, input ready);
    modport sink   (input valid, input accepted, input hit, input tag_out,
                    input order_out, input all_empty, output ready);
endinterface
`default_nettype wire

// ----- src/rat_table.sv -----
// Alias table entries with allocate, completion broadcast and lookup logic.
`default_nettype none
module rat_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire rat_pkg::t_req i_req,
    output rat_pkg::t_rsp      o_rsp
);
    import rat_pkg::*;

    logic [NUM_REGS-1:0] r_valid;
    logic [NUM_REGS-1:0] n_valid;
    logic [TAG_W-1:0]    r_tag   [NUM_REGS];
    logic [TAG_W-1:0]    n_tag   [NUM_REGS];
    logic [ORDER_W-1:0]  r_order [NUM_REGS];
    logic [ORDER_W-1:0]  n_order [NUM_REGS];
    logic                in_range;

    assign in_range = ({{(IDX_CMP_W-IDX_W){1'b0}}, i_req.reg_index} < IDX_CMP_W'(NUM_REGS));

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_order = r_order;
        o_rsp   = '0;
        unique case (i_req.cmd)
            CMD_ALLOC: begin
                if (in_range && (!r_valid[i_req.reg_index] ||
                                 r_order[i_req.reg_index] < i_req.seq_order)) begin
                    n_valid[i_req.reg_index] = 1'b1;
                    n_tag[i_req.reg_index]   = i_req.rs_tag;
                    n_order[i_req.reg_index] = i_req.seq_order;
                    o_rsp.accepted           = 1'b1;
                end
            end
            CMD_DONE: begin
                // Every matching entry clears in the same cycle.
                for (int r = 0; r < NUM_REGS; r++) begin
                    if (r_valid[r] && r_order[r] == i_req.seq_order) begin
                        n_valid[r]     = 1'b0;
                        n_tag[r]       = '0;
                        n_order[r]     = '0;
                        o_rsp.accepted = 1'b1;
                    end
                end
            end
            CMD_LOOKUP: begin
                if (in_range && r_valid[i_req.reg_index]) begin
                    o_rsp.hit       = 1'b1;
                    o_rsp.tag_out   = r_tag[i_req.reg_index];
                    o_rsp.order_out = r_order[i_req.reg_index];
                end
            end
            default: begin
            end
        endcase
        o_rsp.all_empty = ~|n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_step) begin
            r_valid <= n_valid;
        end
    end

    // Tag and order are only observed through a set valid bit.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_tag   <= n_tag;
            r_order <= n_order;
        end
    end
endmodule
`default_nettype wire

// ----- src/register_alias_table_core.sv -----
// Top level of the register alias table: command register, table and result register.
//
// Usage: commands arrive on the i_cmd channel (allocate, completion broadcast or
// lookup) and each one produces exactly one result on the o_rsp channel, in order.
// A transfer on either channel happens at a rising edge with valid and ready high.
// The command is captured in an input register; once the result register is free or
// its result is leaving, the table logic evaluates it against the current entries,
// updates the entries and loads the result register. Throughput is one command per
// cycle while the receiver takes results: the table update and the result register
// load happen together, so a following command always sees the updated entries.
// When the receiver stalls, the result register holds its result and the input
// register holds one more command; i_cmd.ready drops only when both are full.
// A synchronous active-low reset empties the table and drops both register
// stages; no clearing pass is needed because every entry has its own valid bit.
// All-empty is reported with every result and reflects the table after the command.
`default_nettype none
module register_alias_table_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rat_cmd_if.sink   i_cmd,
    rat_rsp_if.source o_rsp
);
    import rat_pkg::*;

    logic r_in_valid;
    t_req r_req;
    logic r_out_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;
    logic advance;

    // The held command moves into the table when the result register is free
    // or its contents are leaving in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_req.cmd       <= i_cmd.cmd;
            r_req.reg_index <= i_cmd.reg_index;
            r_req.rs_tag    <= i_cmd.rs_tag;
            r_req.seq_order <= i_cmd.seq_order;
        end
    end

    rat_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_req),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.accepted  = r_rsp.accepted;
    assign o_rsp.hit       = r_rsp.hit;
    assign o_rsp.tag_out   = r_rsp.tag_out;
    assign o_rsp.order_out = r_rsp.order_out;
    assign o_rsp.all_empty = r_rsp.all_empty;

`ifndef NO_ASSERTIONS
    // A lookup hit means some entry is valid, so the table cannot be empty.
    a_hit_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.hit |-> !r_rsp.all_empty)
        else $error("hit reported with an empty table");

    // A miss carries zero tag and sequence number.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_rsp.hit |-> r_rsp.tag_out == '0 && r_rsp.order_out == '0)
        else $error("miss with nonzero tag or order");

    // A held command that cannot advance is still held in the next cycle.
    a_hold_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_req))
        else $error("held command lost");

    // A result that is not taken stays in the result register.
    a_hold_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_rsp))
        else $error("stalled result lost");

    // The table only advances when the result register can take the result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> !r_out_valid || o_rsp.ready)
        else $error("result register overwritten");
`endif
endmodule
`default_nettype wire
